>>> src/level_triggered_sample_capture_assert.svh
// assertion macros for the level triggered sample capture block
`ifndef LEVEL_TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH
`define LEVEL_TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define LTSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define LTSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTSC_ASSERT(label, prop, msg)
`define LTSC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> src/ltsc_pkg.sv
// shared types and constants for the level triggered sample capture block
package ltsc_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int SAMPLE_BITS  = 12;
  localparam int ADDR_BITS    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int COUNT_BITS   = $clog2(BUFFER_DEPTH + 1);
  localparam int CFG_DATA_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam int KIND_BITS    = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TICK    = 3'd0,
    KIND_TRIGGER = 3'd1,
    KIND_ARM     = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_OFF       = 2'd0,
    PH_ARMED     = 2'd1,
    PH_CAPTURING = 2'd2,
    PH_FINISHED  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SAMPLE_LIMIT      = 2'd0,
    REG_TRIGGER_THRESHOLD = 2'd1
  } reg_index_t;

  // per transaction result of the control logic
  typedef struct packed {
    status_t                status;
    phase_t                 phase;
    logic [COUNT_BITS-1:0]  count;
    logic                   read_ok;
  } ctl_result_t;

endpackage

>>> src/ltsc_store.sv
// sample buffer: one write port, one registered read port
module ltsc_store (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ltsc_pkg::ADDR_BITS-1:0]   wr_addr,
  input  logic [ltsc_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [ltsc_pkg::ADDR_BITS-1:0]   rd_addr,
  output logic [ltsc_pkg::SAMPLE_BITS-1:0] rd_data
);
  import ltsc_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ltsc_ctrl.sv
// capture state, configuration registers and per transaction decode
`include "level_triggered_sample_capture_assert.svh"

module ltsc_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [ltsc_pkg::KIND_BITS-1:0]      kind,
  input  logic [ltsc_pkg::SAMPLE_BITS-1:0]    adc_sample,
  input  logic [ltsc_pkg::ADDR_BITS-1:0]      read_index,
  input  logic                                cfg_write,
  input  logic [ltsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ltsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                wr_en,
  output logic [ltsc_pkg::ADDR_BITS-1:0]      wr_addr,
  output ltsc_pkg::ctl_result_t               result
);
  import ltsc_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_BITS-1:0]  fill_count;
  logic [COUNT_BITS-1:0]  fill_count_next;
  logic [COUNT_BITS-1:0]  sample_limit;
  logic [SAMPLE_BITS-1:0] trigger_threshold;
  logic [COUNT_BITS-1:0]  limit_wdata;
  logic                   buf_has_room;

  assign limit_wdata  = cfg_data[COUNT_BITS-1:0];
  assign buf_has_room = fill_count < COUNT_BITS'(BUFFER_DEPTH);

  always_comb begin
    phase_next      = phase;
    fill_count_next = fill_count;
    wr_en           = 1'b0;
    wr_addr         = fill_count[ADDR_BITS-1:0];
    result.status   = ST_OK;
    result.read_ok  = 1'b0;
    if (take) begin
      case (kind)
        KIND_TICK: begin
          if (phase == PH_ARMED) begin
            if (adc_sample <= trigger_threshold) begin
              // trigger fires: this sample goes to the head of the buffer
              phase_next      = PH_CAPTURING;
              fill_count_next = COUNT_BITS'(1);
              wr_en           = 1'b1;
              wr_addr         = '0;
            end
          end else if (phase == PH_CAPTURING) begin
            if (fill_count < sample_limit) begin
              if (buf_has_room) begin
                wr_en           = 1'b1;
                fill_count_next = fill_count + COUNT_BITS'(1);
              end
            end else begin
              phase_next = PH_FINISHED;
            end
          end
        end
        KIND_TRIGGER, KIND_ARM: begin
          if (phase == PH_CAPTURING) begin
            result.status = ST_BUSY;
          end else begin
            fill_count_next = '0;
            phase_next      = (kind == KIND_TRIGGER) ? PH_CAPTURING : PH_ARMED;
          end
        end
        KIND_STOP: begin
          phase_next      = PH_OFF;
          fill_count_next = '0;
        end
        KIND_READ: begin
          if ({1'b0, read_index} < fill_count) begin
            result.read_ok = 1'b1;
          end else begin
            result.status = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
    result.phase = phase_next;
    result.count = fill_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_OFF;
      fill_count        <= '0;
      sample_limit      <= '0;
      trigger_threshold <= '0;
    end else begin
      phase      <= phase_next;
      fill_count <= fill_count_next;
      // register writes are dropped while a capture runs
      if (cfg_write && phase != PH_CAPTURING) begin
        unique case (cfg_index)
          REG_SAMPLE_LIMIT: begin
            if (limit_wdata <= COUNT_BITS'(BUFFER_DEPTH)) begin
              sample_limit <= limit_wdata;
            end
          end
          REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[SAMPLE_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  `LTSC_ASSERT(a_count_in_range, fill_count <= COUNT_BITS'(BUFFER_DEPTH), "fill count past buffer depth")
  `LTSC_ASSERT(a_write_needs_take, wr_en |-> take && phase_next == PH_CAPTURING, "buffer write outside a capturing tick")
  `LTSC_ASSERT(a_trigger_starts, take && kind == KIND_TRIGGER && phase != PH_CAPTURING |=> phase == PH_CAPTURING && fill_count == '0, "trigger now did not start a capture")
endmodule

>>> src/level_triggered_sample_capture.sv
// an accepted item's result is on the output register in the next cycle
// throughput: one item per cycle while the output is not stalled; the sample buffer has one write and one read port
// a read item takes its data from the buffer's registered read port in that same cycle
// reset clears the phase, the fill count, both config registers and the output valid
// the sample buffer is not cleared; entries at or above the fill count are never returned
`include "level_triggered_sample_capture_assert.svh"

module level_triggered_sample_capture (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ltsc_pkg::KIND_BITS-1:0]      kind,
  input  logic [ltsc_pkg::SAMPLE_BITS-1:0]    adc_sample,
  input  logic [ltsc_pkg::ADDR_BITS-1:0]      read_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [1:0]                          capture_phase,
  output logic [ltsc_pkg::COUNT_BITS-1:0]     captured_count,
  output logic [ltsc_pkg::SAMPLE_BITS-1:0]    read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ltsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ltsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ltsc_pkg::*;

  logic                   take;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic                   rd_en;
  logic [SAMPLE_BITS-1:0] rd_data;
  ctl_result_t            result;
  ctl_result_t            out_reg;

  // output register frees up when empty or when its transaction leaves
  assign in_stall  = out_valid && out_stall;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign rd_en     = take && kind == KIND_READ;

  ltsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .kind       (kind),
    .adc_sample (adc_sample),
    .read_index (read_index),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .result     (result)
  );

  ltsc_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (adc_sample),
    .rd_en   (rd_en),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= result;
    end
  end

  assign status         = out_reg.status;
  assign capture_phase  = out_reg.phase;
  assign captured_count = out_reg.count;
  assign read_value     = out_reg.read_ok ? rd_data : '0;

  `LTSC_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !out_valid, "result valid right after reset")
  `LTSC_ASSERT(a_busy_while_capturing, out_valid && out_reg.status == ST_BUSY |-> out_reg.phase == PH_CAPTURING, "busy status outside a capture")
  `LTSC_ASSERT(a_read_ok_status, out_valid && out_reg.read_ok |-> out_reg.status == ST_OK && out_reg.count != '0, "read returned data beyond the count")
endmodule

>>> tb/level_triggered_sample_capture_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the level triggered sample capture block
module level_triggered_sample_capture_test;
  import ltsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int RANDOM_ROUNDS  = 8;
  localparam int ROUND_ITEMS    = 45;
  localparam int IDLE_PERCENT   = 25;

  // kind codes and register indexes the block must ignore
  localparam logic [KIND_BITS-1:0]      KIND_UNKNOWN_FIRST = 3'd5;
  localparam logic [KIND_BITS-1:0]      KIND_UNKNOWN_LAST  = 3'd7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LAST    = 2'd3;

  typedef struct packed {
    status_t                status;
    phase_t                 phase;
    logic [COUNT_BITS-1:0]  count;
    logic [SAMPLE_BITS-1:0] value;
  } capture_report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_BITS-1:0]      kind = '0;
  logic [SAMPLE_BITS-1:0]    adc_sample = '0;
  logic [ADDR_BITS-1:0]      read_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic [1:0]                capture_phase;
  logic [COUNT_BITS-1:0]     captured_count;
  logic [SAMPLE_BITS-1:0]    read_value;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // shadow copy of the engine state
  logic [COUNT_BITS-1:0]  shadow_limit;
  logic [SAMPLE_BITS-1:0] shadow_threshold;
  phase_t                 shadow_phase;
  logic [COUNT_BITS-1:0]  shadow_fill;
  logic [SAMPLE_BITS-1:0] shadow_store [BUFFER_DEPTH];

  capture_report_t expected_reports[$];

  int mismatches = 0;
  int sent_items = 0;
  int accepted_items = 0;
  int checked_reports = 0;
  int reg_writes = 0;
  int captures_started = 0;
  int captures_finished = 0;
  int idle_cycles = 0;

  bit send_idling = 1'b1;
  bit stall_idling = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  level_triggered_sample_capture DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .adc_sample    (adc_sample),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .capture_phase (capture_phase),
    .captured_count(captured_count),
    .read_value    (read_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic void shadow_store_sample(input logic [SAMPLE_BITS-1:0] smp);
    if (shadow_fill < BUFFER_DEPTH) begin
      shadow_store[shadow_fill[ADDR_BITS-1:0]] = smp;
      shadow_fill++;
    end
  endfunction

  function automatic void shadow_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
    logic [COUNT_BITS-1:0] lim;
    lim = data[COUNT_BITS-1:0];
    // the engine locks its registers while a capture runs
    if (shadow_phase == PH_CAPTURING) return;
    if (idx == REG_SAMPLE_LIMIT) begin
      if (lim <= BUFFER_DEPTH) shadow_limit = lim;
    end else if (idx == REG_TRIGGER_THRESHOLD) begin
      shadow_threshold = data[SAMPLE_BITS-1:0];
    end
  endfunction

  function automatic capture_report_t predict_report(input logic [KIND_BITS-1:0] k,
                                                     input logic [SAMPLE_BITS-1:0] smp,
                                                     input logic [ADDR_BITS-1:0] idx);
    capture_report_t r;
    r = '0;
    r.status = ST_OK;
    case (k)
      KIND_TICK: begin
        if (shadow_phase == PH_ARMED) begin
          if (smp <= shadow_threshold) begin
            shadow_phase = PH_CAPTURING;
            shadow_fill = '0;
            captures_started++;
            shadow_store_sample(smp);
          end
        end else if (shadow_phase == PH_CAPTURING) begin
          if (shadow_fill < shadow_limit) begin
            shadow_store_sample(smp);
          end else begin
            shadow_phase = PH_FINISHED;
            captures_finished++;
          end
        end
      end
      KIND_TRIGGER, KIND_ARM: begin
        if (shadow_phase == PH_CAPTURING) begin
          r.status = ST_BUSY;
        end else begin
          shadow_fill = '0;
          shadow_phase = (k == KIND_TRIGGER) ? PH_CAPTURING : PH_ARMED;
          if (k == KIND_TRIGGER) captures_started++;
        end
      end
      KIND_STOP: begin
        shadow_phase = PH_OFF;
        shadow_fill = '0;
      end
      KIND_READ: begin
        if (idx < shadow_fill) r.value = shadow_store[idx];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.phase = shadow_phase;
    r.count = shadow_fill;
    return r;
  endfunction

  // scoreboard: predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    capture_report_t want;
    if (rst) begin
      shadow_limit = '0;
      shadow_threshold = '0;
      shadow_phase = PH_OFF;
      shadow_fill = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shadow_reg_write(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_report(kind, adc_sample, read_index));
        accepted_items++;
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result transaction with no input outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("status", status, want.status);
          check_field("capture_phase", capture_phase, want.phase);
          check_field("captured_count", captured_count, want.count);
          check_field("read_value", read_value, want.value);
        end
        checked_reports++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = stall_idling && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input logic [KIND_BITS-1:0] k,
                           input logic [SAMPLE_BITS-1:0] smp,
                           input logic [ADDR_BITS-1:0] idx);
    while (send_idling && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    adc_sample = smp;
    read_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_read(input logic [ADDR_BITS-1:0] idx);
    send_item(KIND_READ, SAMPLE_BITS'($urandom), idx);
  endtask

  task automatic send_tick(input logic [SAMPLE_BITS-1:0] smp);
    send_item(KIND_TICK, smp, ADDR_BITS'($urandom));
  endtask

  task automatic test_basic_operations();
    logic [KIND_BITS-1:0] k;
    send_read(0);
    send_tick(12'hfff);
    for (k = KIND_UNKNOWN_FIRST; k != KIND_UNKNOWN_LAST; k++)
      send_item(k, SAMPLE_BITS'($urandom), ADDR_BITS'($urandom));
    send_item(KIND_UNKNOWN_LAST, 12'hfff, 10'h3ff);
    write_reg(REG_SAMPLE_LIMIT, 3);
    write_reg(REG_TRIGGER_THRESHOLD, 2048);
    send_item(KIND_ARM, 0, 0);
    send_tick(12'hfff);
    send_tick(2049);
    send_tick(2048);                 // exactly at the level fires
    send_item(KIND_TRIGGER, 0, 0);   // busy
    send_item(KIND_ARM, 0, 0);       // busy
    send_tick(0);
    send_tick(12'hfff);
    send_tick(7);                    // limit reached, finishes
    send_tick(1);
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(3);
    send_read(10'h3ff);
    send_item(KIND_STOP, 0, 0);
    send_read(0);
  endtask

  task automatic test_register_edges();
    write_reg(REG_SAMPLE_LIMIT, 0);
    write_reg(REG_TRIGGER_THRESHOLD, 12'hfff);
    send_item(KIND_ARM, 0, 0);
    send_tick(12'hfff);              // zero limit still keeps the trigger sample
    send_tick(0);
    send_read(0);
    send_item(KIND_TRIGGER, 0, 0);
    // writes while capturing are dropped
    write_reg(REG_TRIGGER_THRESHOLD, 0);
    write_reg(REG_SAMPLE_LIMIT, 5);
    send_tick(100);
    write_reg(REG_TRIGGER_THRESHOLD, 0);
    send_item(KIND_ARM, 0, 0);
    send_tick(1);
    send_tick(0);
    send_item(KIND_STOP, 0, 0);
    write_reg(REG_SAMPLE_LIMIT, 2);
    write_reg(REG_SAMPLE_LIMIT, BUFFER_DEPTH + 1);
    write_reg(REG_SAMPLE_LIMIT, 12'hfff);
    write_reg(REG_UNUSED_FIRST, 12'hfff);
    write_reg(REG_UNUSED_LAST, 12'hfff);
    send_item(KIND_TRIGGER, 0, 0);
    repeat (3) send_tick(SAMPLE_BITS'($urandom));
    send_read(1);
    write_reg(REG_SAMPLE_LIMIT, 12'h801);  // upper bit falls outside the field
    send_item(KIND_TRIGGER, 0, 0);
    repeat (2) send_tick(SAMPLE_BITS'($urandom));
  endtask

  task automatic test_full_depth();
    write_reg(REG_SAMPLE_LIMIT, BUFFER_DEPTH);
    send_item(KIND_TRIGGER, 0, 0);
    repeat (BUFFER_DEPTH) send_tick(SAMPLE_BITS'($urandom));
    send_tick(SAMPLE_BITS'($urandom));
    send_read(0);
    send_read(BUFFER_DEPTH - 1);
    repeat (8) send_read(ADDR_BITS'($urandom));
    write_reg(REG_SAMPLE_LIMIT, 0);
  endtask

  task automatic test_output_backpressure();
    write_reg(REG_SAMPLE_LIMIT, 8);
    write_reg(REG_TRIGGER_THRESHOLD, 12'hfff);
    send_idling = 1'b0;
    hold_requests++;
    send_item(KIND_ARM, 0, 0);
    repeat (12) send_tick(SAMPLE_BITS'($urandom));
    repeat (20) send_read(ADDR_BITS'($urandom_range(0, 9)));
    send_item(KIND_STOP, 0, 0);
    wait_drained();
    send_idling = 1'b1;
  endtask

  task automatic send_noise_item();
    send_item(KIND_BITS'($urandom_range(0, 7)), SAMPLE_BITS'($urandom),
              ADDR_BITS'($urandom));
  endtask

  task automatic run_capture_sequence();
    int ticks;
    int pick;
    send_item(($urandom_range(0, 99) < 60) ? KIND_ARM : KIND_TRIGGER,
              SAMPLE_BITS'($urandom), ADDR_BITS'($urandom));
    ticks = ((shadow_limit > 40) ? 40 : shadow_limit) + $urandom_range(1, 6);
    repeat (ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) send_noise_item();
      else if (pick < 18) send_read(ADDR_BITS'($urandom_range(0, shadow_fill)));
      else if (pick < 50) send_tick(SAMPLE_BITS'($urandom_range(0, shadow_threshold)));
      else send_tick(SAMPLE_BITS'($urandom));
    end
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 99) < 80) send_read(ADDR_BITS'($urandom_range(0, shadow_fill)));
      else send_read(ADDR_BITS'($urandom));
    end
    if ($urandom_range(0, 99) < 30)
      send_item(KIND_STOP, SAMPLE_BITS'($urandom), ADDR_BITS'($urandom));
  endtask

  task automatic test_random_traffic();
    int target;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case (round % 4)
        0: write_reg(REG_SAMPLE_LIMIT, 0);
        1: write_reg(REG_SAMPLE_LIMIT, CFG_DATA_BITS'($urandom_range(1, 4)));
        2: write_reg(REG_SAMPLE_LIMIT, CFG_DATA_BITS'($urandom_range(5, 40)));
        default: write_reg(REG_SAMPLE_LIMIT, CFG_DATA_BITS'($urandom));
      endcase
      case (round % 3)
        0: write_reg(REG_TRIGGER_THRESHOLD, 0);
        1: write_reg(REG_TRIGGER_THRESHOLD, 12'hfff);
        default: write_reg(REG_TRIGGER_THRESHOLD, CFG_DATA_BITS'($urandom));
      endcase
      if (round % 4 == 3)
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                  CFG_DATA_BITS'($urandom));
      // two rounds in a row with no idling on either side
      send_idling = (round != 6 && round != 7);
      stall_idling = send_idling;
      target = sent_items + ROUND_ITEMS;
      while (sent_items < target) begin
        if ($urandom_range(0, 99) < 85) run_capture_sequence();
        else send_noise_item();
      end
    end
    send_idling = 1'b1;
    stall_idling = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_operations();
    test_register_edges();
    test_full_depth();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    $display("run covered %0d items in, %0d results checked, %0d register writes",
             accepted_items, checked_reports, reg_writes);
    $display("captures started %0d, captures finished %0d, mismatches %0d",
             captures_started, captures_finished, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
